FILE: rtl/lorentz_ade_cell_update_top_defines.svh
// Assertion macros for the Lorentz ADE cell update block.
// Included by the top level; ASSERT_OFF removes every check.
`ifndef LORENTZ_ADE_CELL_UPDATE_TOP_DEFINES_SVH
`define LORENTZ_ADE_CELL_UPDATE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, disabled while reset is applied
`define LADE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked property, also sampled during reset
`define LADE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LADE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LADE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/lade_pkg.sv
// Types, codes and fixed-point helpers for the Lorentz ADE cell update.
// No dependencies.
`timescale 1ns / 1ps

package lade_pkg;

	localparam int VAL_W  = 32;  // Q16.16 values
	localparam int COEF_W = 32;  // Q2.30 coefficients
	localparam int MA_W   = 33;  // multiplier value operand (holds field - lor)
	localparam int PROD_W = 65;  // exact product
	localparam int RND_W  = 35;  // rounded product in Q16.16
	localparam int SUM_W  = 36;  // exact sum before saturation
	localparam int MASK_W = 4;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VOLT_ADE = 3'd0,
		CFG_VOLT_LOR = 3'd1,
		CFG_CURR_ADE = 3'd2,
		CFG_CURR_LOR = 3'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LMUL,
		ST_LADD,
		ST_IMUL,
		ST_IACC,
		ST_EMUL,
		ST_WB
	} state_t;

	typedef struct packed {
		logic                    clip;
		logic signed [VAL_W-1:0] val;
	} sat_t;

	// round half up to Q16.16: add 2^29, floor shift by 30
	function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = p + (PROD_W'(1) <<< 29);
		return r[PROD_W-1:30];
	endfunction

	function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
		sat_t s;
		if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
			s.clip = 1'b0;
			s.val  = v[VAL_W-1:0];
		end else begin
			s.clip = 1'b1;
			s.val  = v[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s;
	endfunction

endpackage

FILE: rtl/lorentz_ade_cell_update_top.sv
// Lorentz ADE cell update: state memories, sequencer and shared multiplier.
// Depends on lade_pkg and lorentz_ade_cell_update_top_defines.svh.
`timescale 1ns / 1ps
`include "lorentz_ade_cell_update_top_defines.svh"

// Usage
// - Request channel: start with field_kind, pole, component, cell_req,
//   field_value and the three coefficients. A request is taken at a clock
//   edge where start is high and busy is low.
// - Result channel: done is high for exactly one cycle with ade_out,
//   lorentz_out, updated and saturated. The receiver cannot stall; the
//   result must be taken in that cycle.
// - Config port: cfg_we, cfg_index, cfg_data write one enable mask per edge;
//   indexes past the four masks are dropped. Write only while idle.
// - Timing: one request at a time. After the request edge the block is busy
//   through READ, LMUL and LADD when the Lorentz term is on, then IMUL, IACC,
//   EMUL and WB; a disabled pole, component three or an out-of-range cell goes
//   from READ straight to WB. done rises in the cycle after WB, and a new request
//   may be taken in that same cycle. The sequence is set by the single 33x32
//   multiplier, used up to three times per request, and the registered memory read.
// - Reset: masks clear, then a clearing pass writes zero to every entry of
//   both state memories, one entry a cycle, 2*POLES*3*CELLS entries in all
//   (98304 at the defaults). busy stays high during the pass; config writes
//   are taken as usual.
// - A request's write-back lands before the next request's read, so
//   back-to-back requests to one entry need no forwarding.
module lorentz_ade_cell_update_top
	import lade_pkg::*;
#(
	parameter int CELLS = 4096,
	parameter int POLES = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// config port
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [MASK_W-1:0]           cfg_data,
	// request channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        field_kind,
	input  logic [1:0]                  pole,
	input  logic [1:0]                  component,
	input  logic [11:0]                 cell_req,
	input  logic signed [VAL_W-1:0]     field_value,
	input  logic signed [COEF_W-1:0]    coef_lorentz,
	input  logic signed [COEF_W-1:0]    coef_internal,
	input  logic signed [COEF_W-1:0]    coef_external,
	// result channel
	output logic                        done,
	output logic signed [VAL_W-1:0]     ade_out,
	output logic signed [VAL_W-1:0]     lorentz_out,
	output logic                        updated,
	output logic                        saturated
);

	localparam int ENTRIES = 2 * POLES * 3 * CELLS;
	localparam int AW      = $clog2(ENTRIES);
	// index bound for the address width; counts component values up to two only
	localparam int MAX_IDX = ((POLES + 3) * 3 + 2) * CELLS + 4095;
	localparam int IW      = $clog2(MAX_IDX + 1);
	localparam int SLOT_MAX = (POLES + 3) * 3 + 2;
	localparam int SW      = $clog2(SLOT_MAX + 1);

	// config masks
	logic [MASK_W-1:0] volt_ade_q, volt_lor_q, curr_ade_q, curr_lor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_ade_q <= '0;
			volt_lor_q <= '0;
			curr_ade_q <= '0;
			curr_lor_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_VOLT_ADE: volt_ade_q <= cfg_data;
				CFG_VOLT_LOR: volt_lor_q <= cfg_data;
				CFG_CURR_ADE: curr_ade_q <= cfg_data;
				CFG_CURR_LOR: curr_lor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic   accept;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// request decode: entry address and enables
	logic [MASK_W-1:0] ade_mask, lor_mask;
	logic [SW-1:0]     slot;
	logic [IW-1:0]     idx_wide;
	logic [AW-1:0]     addr_d;
	logic              valid_d, ade_en_d, lor_en_d;

	always_comb begin
		ade_mask = field_kind ? curr_ade_q : volt_ade_q;
		lor_mask = field_kind ? curr_lor_q : volt_lor_q;
		slot     = SW'((32'(field_kind) * POLES + 32'(pole)) * 3 + 32'(component));
		idx_wide = IW'(slot) * IW'(CELLS) + IW'(cell_req);
		addr_d   = (32'(idx_wide) >= ENTRIES) ? '0 : AW'(idx_wide);
		valid_d  = (component != 2'd3) && (32'(cell_req) < CELLS);
		ade_en_d = (32'(pole) < POLES) && ade_mask[pole];
		lor_en_d = lor_mask[pole];
	end

	// request context
	logic [AW-1:0]             addr_q;
	logic                      valid_q, ade_en_q, lor_en_q;
	logic signed [VAL_W-1:0]   field_q;
	logic signed [COEF_W-1:0]  clor_q, cint_q, cext_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= addr_d;
			valid_q  <= valid_d;
			ade_en_q <= ade_en_d;
			lor_en_q <= lor_en_d;
			field_q  <= field_value;
			clor_q   <= coef_lorentz;
			cint_q   <= coef_internal;
			cext_q   <= coef_external;
		end
	end

	// clearing pass counter
	logic [AW-1:0] clr_q;
	logic          clr_last;
	assign clr_last = (clr_q == AW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// sequencer
	logic do_upd;
	assign do_upd = valid_q && ade_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_READ;
			ST_READ: begin
				if (!do_upd) state_d = ST_WB;
				else if (lor_en_q) state_d = ST_LMUL;
				else state_d = ST_IMUL;
			end
			ST_LMUL: state_d = ST_LADD;
			ST_LADD: state_d = ST_IMUL;
			ST_IMUL: state_d = ST_IACC;
			ST_IACC: state_d = ST_EMUL;
			ST_EMUL: state_d = ST_WB;
			ST_WB:   state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state memories, one write port and one read port each
	logic signed [VAL_W-1:0] ade_mem [ENTRIES];
	logic signed [VAL_W-1:0] lor_mem [ENTRIES];
	logic signed [VAL_W-1:0] ade_rd_q, lor_rd_q;
	logic                    ade_we, lor_we;
	logic [AW-1:0]           wr_addr;
	logic signed [VAL_W-1:0] ade_wdata, lor_wdata;
	logic                    rd_en;

	always_ff @(posedge clk) begin
		if (ade_we) ade_mem[wr_addr] <= ade_wdata;
		if (rd_en)  ade_rd_q <= ade_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (lor_we) lor_mem[wr_addr] <= lor_wdata;
		if (rd_en)  lor_rd_q <= lor_mem[addr_q];
	end

	// shared multiplier and arithmetic
	logic signed [MA_W-1:0]   mul_a, lor_diff;
	logic signed [COEF_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p, prod_q;
	logic signed [RND_W-1:0]  acc_q;
	logic signed [VAL_W-1:0]  lor_q;
	logic                     clip_q;
	sat_t                     lor_sat, ade_sat;

	always_comb begin
		lor_diff = MA_W'(field_q) - MA_W'(lor_q);
		mul_a    = MA_W'(ade_rd_q);
		mul_b    = cint_q;
		case (state_q)
			ST_LMUL: mul_b = clor_q;
			ST_EMUL: begin
				mul_a = lor_en_q ? lor_diff : MA_W'(field_q);
				mul_b = cext_q;
			end
			default: ;
		endcase
		mul_p   = mul_a * mul_b;
		lor_sat = sat32(SUM_W'(lor_rd_q) + SUM_W'(qround(prod_q)));
		ade_sat = sat32(SUM_W'(acc_q) + SUM_W'(qround(prod_q)));
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LMUL || state_q == ST_IMUL || state_q == ST_EMUL) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_LADD) begin
			lor_q  <= lor_sat.val;
			clip_q <= lor_sat.clip;
		end
		if (state_q == ST_IMUL && !lor_en_q) begin
			lor_q  <= lor_rd_q;
			clip_q <= 1'b0;
		end
		if (state_q == ST_IACC) begin
			acc_q <= qround(prod_q);
		end
	end

	// memory port control
	always_comb begin
		rd_en     = (state_q == ST_READ);
		ade_we    = 1'b0;
		lor_we    = 1'b0;
		wr_addr   = addr_q;
		ade_wdata = ade_sat.val;
		lor_wdata = lor_q;
		if (state_q == ST_CLEAR) begin
			ade_we    = 1'b1;
			lor_we    = 1'b1;
			wr_addr   = clr_q;
			ade_wdata = '0;
			lor_wdata = '0;
		end else if (state_q == ST_WB && do_upd) begin
			ade_we = 1'b1;
			lor_we = lor_en_q;
		end
	end

	// result register
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_WB);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WB) begin
			if (!valid_q) begin
				ade_out     <= '0;
				lorentz_out <= '0;
				updated     <= 1'b0;
				saturated   <= 1'b0;
			end else if (!ade_en_q) begin
				ade_out     <= ade_rd_q;
				lorentz_out <= lor_rd_q;
				updated     <= 1'b0;
				saturated   <= 1'b0;
			end else begin
				ade_out     <= ade_sat.val;
				lorentz_out <= lor_q;
				updated     <= 1'b1;
				saturated   <= clip_q || ade_sat.clip;
			end
		end
	end

	assign done = done_q;

	// checks
	`LADE_ASSERT(a_done_after_wb, clk, arst_n, done_q |-> $past(state_q) == ST_WB, "done without write-back")
	`LADE_ASSERT(a_accept_reads, clk, arst_n, accept |=> state_q == ST_READ, "request not followed by read")
	`LADE_ASSERT(a_we_states, clk, arst_n, (ade_we || lor_we) |-> (state_q == ST_CLEAR || state_q == ST_WB), "memory write outside clear or write-back")
	`LADE_ASSERT_ALWAYS(a_lor_with_ade, clk, (lor_we && state_q == ST_WB) |-> ade_we, "Lorentz write without ADE write")

endmodule

FILE: verif/tb_lorentz_ade_cell_update_top.sv
// Testbench for lorentz_ade_cell_update_top: directed and random cell update requests,
// each result checked against an in-bench Q16.16 / Q2.30 predictor of the ADE state.
// Depends on lade_pkg and the RTL of lorentz_ade_cell_update_top.
`timescale 1ns / 1ps

module tb_lorentz_ade_cell_update_top;
	import lade_pkg::*;

	localparam int CELLS = 4096;
	localparam int POLES = 4;
	// any index past the four masks; the block must drop the write
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	// cycles allowed after the last result for stray strobes
	localparam int TAIL_CYCLES = 24;

	localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN  = 32'h8000_0000;
	localparam logic [31:0] C_ONE  = 32'h4000_0000;  // 1.0 in Q2.30
	localparam logic [31:0] C_HALF = 32'h2000_0000;  // 0.5 in Q2.30

	// wide enough for (field - lor) times a coefficient without overflow
	typedef logic signed [65:0] wide_t;
	localparam wide_t VAL_MAX = 66'sd2147483647;
	localparam wide_t VAL_MIN = -66'sd2147483648;

	typedef struct {
		logic                     kind;
		logic [1:0]               pole_ix;
		logic [1:0]               comp;
		logic [11:0]              cell_ix;
		logic signed [VAL_W-1:0]  fld;
		logic signed [COEF_W-1:0] c_lor;
		logic signed [COEF_W-1:0] c_int;
		logic signed [COEF_W-1:0] c_ext;
	} upd_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] ade;
		logic signed [VAL_W-1:0] lor;
		logic                    upd;
		logic                    sat;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MASK_W-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic field_kind = 1'b0;
	logic [1:0] pole = '0;
	logic [1:0] component = '0;
	logic [11:0] cell_req = '0;
	logic signed [VAL_W-1:0] field_value = '0;
	logic signed [COEF_W-1:0] coef_lorentz = '0;
	logic signed [COEF_W-1:0] coef_internal = '0;
	logic signed [COEF_W-1:0] coef_external = '0;
	logic done;
	logic signed [VAL_W-1:0] ade_out;
	logic signed [VAL_W-1:0] lorentz_out;
	logic updated;
	logic saturated;

	// predictor state: enable masks and the two state memories (unwritten = zero)
	logic [MASK_W-1:0] volt_ade_m = '0;
	logic [MASK_W-1:0] volt_lor_m = '0;
	logic [MASK_W-1:0] curr_ade_m = '0;
	logic [MASK_W-1:0] curr_lor_m = '0;
	logic signed [31:0] ade_mem [int unsigned];
	logic signed [31:0] lor_mem [int unsigned];

	// results still owed by the block, oldest first
	cell_result_t pending_results[$];
	int mismatches = 0;

	lorentz_ade_cell_update_top #(
		.CELLS(CELLS),
		.POLES(POLES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.field_kind(field_kind),
		.pole(pole),
		.component(component),
		.cell_req(cell_req),
		.field_value(field_value),
		.coef_lorentz(coef_lorentz),
		.coef_internal(coef_internal),
		.coef_external(coef_external),
		.done(done),
		.ade_out(ade_out),
		.lorentz_out(lorentz_out),
		.updated(updated),
		.saturated(saturated)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// value times Q2.30 coefficient, rounded half up back to Q16.16
	function automatic wide_t qscale(wide_t v, logic signed [COEF_W-1:0] c);
		wide_t cw;
		wide_t p;
		cw = c;
		p = v * cw + (wide_t'(1) <<< 29);
		return p >>> 30;
	endfunction

	function automatic sat_t clamp_q16(wide_t v);
		sat_t s;
		s.clip = 1'b1;
		if (v > VAL_MAX)
			s.val = Q_MAX;
		else if (v < VAL_MIN)
			s.val = Q_MIN;
		else begin
			s.clip = 1'b0;
			s.val = v[31:0];
		end
		return s;
	endfunction

	// one ADE step on the entry the request names; updates the predictor memories
	function automatic cell_result_t ade_cell_predict(upd_req_t r);
		cell_result_t res;
		int unsigned idx;
		logic [MASK_W-1:0] ade_m;
		logic [MASK_W-1:0] lor_m;
		wide_t ade;
		wide_t lor;
		wide_t fld;
		wide_t acc;
		sat_t s;
		res = '0;
		// component three (or a cell past the table) is dropped, all zeros back
		if (r.comp == 2'd3 || r.cell_ix >= CELLS)
			return res;
		idx = ((int'(r.kind) * POLES + int'(r.pole_ix)) * 3 + int'(r.comp)) * CELLS
			+ int'(r.cell_ix);
		ade = 0;
		lor = 0;
		if (ade_mem.exists(idx))
			ade = ade_mem[idx];
		if (lor_mem.exists(idx))
			lor = lor_mem[idx];
		fld = r.fld;
		res.ade = ade[31:0];
		res.lor = lor[31:0];
		ade_m = r.kind ? curr_ade_m : volt_ade_m;
		lor_m = r.kind ? curr_lor_m : volt_lor_m;
		// disabled pole: stored values shown, nothing written
		if (r.pole_ix < POLES && ade_m[r.pole_ix]) begin
			res.upd = 1'b1;
			if (lor_m[r.pole_ix]) begin
				s = clamp_q16(lor + qscale(ade, r.c_lor));
				res.sat = s.clip;
				res.lor = s.val;
				lor_mem[idx] = s.val;
				lor = s.val;
				// the drive term uses the freshly updated Lorentz value
				acc = qscale(ade, r.c_int) + qscale(fld - lor, r.c_ext);
			end else begin
				acc = qscale(ade, r.c_int) + qscale(fld, r.c_ext);
			end
			s = clamp_q16(acc);
			res.sat = res.sat | s.clip;
			res.ade = s.val;
			ade_mem[idx] = s.val;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("%0t ns: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		mismatches++;
	endtask

	// done is sampled at the edge that ends its cycle; values are pre-edge
	always @(posedge clk) begin
		if (arst_n && done) begin
			cell_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("done with no request outstanding", 32'd0, 32'd1);
			end else begin
				want = pending_results.pop_front();
				if (ade_out !== want.ade)
					report_mismatch("ade_out", want.ade, ade_out);
				if (lorentz_out !== want.lor)
					report_mismatch("lorentz_out", want.lor, lorentz_out);
				if (updated !== want.upd)
					report_mismatch("updated", 32'(want.upd), 32'(updated));
				if (saturated !== want.sat)
					report_mismatch("saturated", 32'(want.sat), 32'(saturated));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers (all called on a rising-edge time step)
	// ---------------------------------------------------------------

	function automatic upd_req_t mk_req(logic kind, logic [1:0] p, logic [1:0] comp,
			logic [11:0] c, logic [31:0] f, logic [31:0] cl, logic [31:0] ci,
			logic [31:0] ce);
		upd_req_t r;
		r.kind = kind;
		r.pole_ix = p;
		r.comp = comp;
		r.cell_ix = c;
		r.fld = f;
		r.c_lor = cl;
		r.c_int = ci;
		r.c_ext = ce;
		return r;
	endfunction

	// Send one request. Start is left high on return so a following request
	// can go out back to back; idle cycles drop it first.
	task automatic issue_request(upd_req_t r, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		field_kind <= r.kind;
		pole <= r.pole_ix;
		component <= r.comp;
		cell_req <= r.cell_ix;
		field_value <= r.fld;
		coef_lorentz <= r.c_lor;
		coef_internal <= r.c_int;
		coef_external <= r.c_ext;
		// taken at the first edge where busy was low
		do @(posedge clk); while (busy);
		pending_results.push_back(ade_cell_predict(r));
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write enable stays high across consecutive writes; caller lowers it
	task automatic write_reg(logic [CFG_IDX_W-1:0] ix, logic [MASK_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic write_masks(logic [3:0] va, logic [3:0] vl, logic [3:0] ca,
			logic [3:0] cl);
		write_reg(CFG_VOLT_ADE, va);
		write_reg(CFG_VOLT_LOR, vl);
		write_reg(CFG_CURR_ADE, ca);
		write_reg(CFG_CURR_LOR, cl);
		// out-of-range index: must leave all masks alone
		write_reg(CFG_SPARE, ~va);
		cfg_we <= 1'b0;
		volt_ade_m = va;
		volt_lor_m = vl;
		curr_ade_m = ca;
		curr_lor_m = cl;
	endtask

	// coefficients: mostly within +-1.0 so the state lives a while, some full range
	function automatic logic [31:0] rand_coef();
		case ($urandom_range(7))
			0: return $urandom;
			1: return Q_MAX;
			2: return Q_MIN;
			default: return 32'($urandom_range(32'h8000_0000)) - C_ONE;
		endcase
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(7))
			0: return $urandom;
			1: return $urandom_range(1) ? Q_MAX : Q_MIN;
			default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	// a small hot set of cells so entries get revisited and state builds up
	function automatic upd_req_t rand_req();
		logic [11:0] c;
		logic [1:0] comp;
		case ($urandom_range(9))
			0: c = 12'($urandom_range(4095));
			1: c = 12'd0;
			2: c = 12'd4095;
			default: c = 12'd16 + 12'($urandom_range(3));
		endcase
		comp = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
		return mk_req(1'($urandom_range(1)), 2'($urandom_range(3)), comp, c, rand_field(),
			rand_coef(), rand_coef(), rand_coef());
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Masks written during the clearing pass; then the requested entries must read
	// zero and nothing may update.
	task automatic test_cleared_state();
		write_masks(4'h0, 4'h0, 4'h0, 4'h0);
		do @(posedge clk); while (busy);
		issue_request(mk_req(1'b0, 2'd0, 2'd0, 12'd0, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0);
		issue_request(mk_req(1'b1, 2'd3, 2'd2, 12'd4095, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 0);
		issue_request(mk_req(1'b0, 2'd1, 2'd3, 12'd7, Q_MAX, C_ONE, C_ONE, C_ONE), 0);
		drain_results();
	endtask

	// Saturation both ways, the 33-bit field - lor difference, rounding of
	// exact halves, Lorentz on and off, disabled pole and component three.
	task automatic test_directed_updates();
		write_masks(4'hf, 4'b0101, 4'hf, 4'b1010);
		// pole 0 voltage, Lorentz on: drive to +max, clipped
		issue_request(mk_req(1'b0, 2'd0, 2'd1, 12'd5, Q_MAX, 32'd0, 32'd0, Q_MAX), 0);
		// lor clips high, field - lor spans 33 bits, ade clips
		issue_request(mk_req(1'b0, 2'd0, 2'd1, 12'd5, Q_MIN, Q_MAX, Q_MIN, Q_MIN), 0);
		issue_request(mk_req(1'b0, 2'd0, 2'd1, 12'd5, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 0);
		// pole 1 voltage, Lorentz off: drive to -max
		issue_request(mk_req(1'b0, 2'd1, 2'd0, 12'd0, Q_MIN, 32'd0, 32'd0, Q_MAX), 0);
		issue_request(mk_req(1'b0, 2'd1, 2'd0, 12'd0, 32'd0, Q_MAX, C_ONE, 32'd0), 0);
		// exact half LSB: +0.5 rounds up, -0.5 rounds to zero
		issue_request(mk_req(1'b0, 2'd2, 2'd2, 12'd9, 32'd1, 32'd0, 32'd0, C_HALF), 0);
		issue_request(mk_req(1'b0, 2'd3, 2'd2, 12'd9, 32'hffff_ffff, 32'd0, 32'd0, C_HALF), 0);
		// current kind uses its own masks and coefficients
		issue_request(mk_req(1'b1, 2'd1, 2'd2, 12'd4095, 32'h0003_0000, C_HALF, C_ONE,
			C_ONE), 0);
		issue_request(mk_req(1'b1, 2'd1, 2'd2, 12'd4095, 32'hfffd_0000, C_ONE, C_HALF,
			32'hc000_0000), 0);
		issue_request(mk_req(1'b1, 2'd0, 2'd2, 12'd4095, 32'h0001_8000, C_ONE, C_ONE,
			C_ONE), 0);
		// component three is dropped even with everything enabled
		issue_request(mk_req(1'b1, 2'd3, 2'd3, 12'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0);
		drain_results();
		// disable the updated poles: stored values must show, unchanged
		write_masks(4'b1100, 4'b0101, 4'b0101, 4'b0000);
		issue_request(mk_req(1'b0, 2'd0, 2'd1, 12'd5, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0);
		issue_request(mk_req(1'b0, 2'd1, 2'd0, 12'd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 0);
		issue_request(mk_req(1'b1, 2'd1, 2'd2, 12'd4095, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0);
		// pole 0 current: Lorentz now off, lor entry held
		issue_request(mk_req(1'b1, 2'd0, 2'd2, 12'd4095, 32'h0002_0000, Q_MAX, C_HALF,
			C_ONE), 0);
		drain_results();
	endtask

	// Random requests at a given idle rate; now and then the sender holds off
	// until the block has returned everything.
	task automatic test_random_traffic(int n, int idle_pct);
		for (int i = 0; i < n; i++) begin
			issue_request(rand_req(), idle_pct);
			if ($urandom_range(99) < 2)
				drain_results();
		end
		drain_results();
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_cleared_state();
		test_directed_updates();
		// everything on, back-to-back requests
		write_masks(4'hf, 4'hf, 4'hf, 4'hf);
		test_random_traffic(250, 0);
		// mixed masks, sender idles before about half of the requests
		write_masks(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
		test_random_traffic(250, 48);
		write_masks(4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom));
		test_random_traffic(250, 32);
		// ADE without Lorentz for voltage, only Lorentz-marked for current
		write_masks(4'hf, 4'h0, 4'h0, 4'hf);
		test_random_traffic(60, 0);
		drain_results();
		// catch any result strobe nobody asked for
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_lorentz_ade_cell_update_top passed");
		else
			$display("tb_lorentz_ade_cell_update_top failed");
		$finish;
	end

	// Watchdog: clearing pass over ~98k entries plus ~830 requests with idle
	// gaps is under 2 ms; allow ten times that.
	initial begin
		#20_000_000;
		$display("tb_lorentz_ade_cell_update_top failed");
		$finish;
	end

endmodule

FILE: lorentz_ade_cell_update_top.f
+incdir+rtl
rtl/lade_pkg.sv
rtl/lorentz_ade_cell_update_top.sv
verif/tb_lorentz_ade_cell_update_top.sv
